>>> design/assert_macros.svh
// assertion macros included by upwind_edge_emf.sv
// each check is clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

>>> design/upw_pkg.sv
package upw_pkg;

  // default width of each emf value
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // velocity sign codes
  localparam logic [1:0] SIGN_ZERO    = 2'b00;
  localparam logic [1:0] SIGN_POS     = 2'b01;
  localparam logic [1:0] SIGN_NEG_ALT = 2'b10;
  localparam logic [1:0] SIGN_NEG     = 2'b11;

endpackage

>>> design/upwind_edge_emf.sv
// upwinded edge emf for constrained-transport mhd
//
// input channel: four face emfs, four cell-centred emfs and four normal
// velocity signs arrive as one request, taken at a rising edge where
// in_valid_i is high and in_stall_o is low. output channel: edge_emf_o and
// overflow_o, taken where out_valid_o is high and out_stall_i is low.
// values are signed fixed point; all operands share one format.
//
// a request passes four register stages, the first loaded at the edge that
// accepts it: correction terms, partial sums, exact total at eight times
// scale, then floor shift and saturation into the output register;
// out_valid_o is the valid bit of that last stage. throughput is one
// request per cycle while out_stall_i is low, set by the per-stage
// handshake; overflow_o flags a saturated result.
//
// reset empties every stage; no result is pending afterwards. when the
// receiver stalls, the output holds and each stage fills its bubble before
// in_stall_o rises, so nothing is dropped or repeated.
`include "assert_macros.svh"

module upwind_edge_emf
  import upw_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] face_emf_0_i,
  input  logic signed [VALUE_WIDTH-1:0] face_emf_1_i,
  input  logic signed [VALUE_WIDTH-1:0] face_emf_2_i,
  input  logic signed [VALUE_WIDTH-1:0] face_emf_3_i,
  input  logic signed [VALUE_WIDTH-1:0] cell_emf_0_i,
  input  logic signed [VALUE_WIDTH-1:0] cell_emf_1_i,
  input  logic signed [VALUE_WIDTH-1:0] cell_emf_2_i,
  input  logic signed [VALUE_WIDTH-1:0] cell_emf_3_i,
  input  logic signed [1:0]             vel_sign_0_i,
  input  logic signed [1:0]             vel_sign_1_i,
  input  logic signed [1:0]             vel_sign_2_i,
  input  logic signed [1:0]             vel_sign_3_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VALUE_WIDTH-1:0] edge_emf_o,
  output logic                          overflow_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned DW = W + 1;  // difference of two values
  localparam int unsigned TW = W + 2;  // one correction term, times eight
  localparam int unsigned PW = W + 3;  // partial sums
  localparam int unsigned AW = W + 5;  // exact total, times eight
  localparam int unsigned SW = AW - 3; // total after the divide by eight

  // saturation limits
  localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  // one correction term at eight times scale
  function automatic logic signed [TW-1:0] corr(
    input logic [1:0]         sgn,
    input logic signed [W-1:0] a,
    input logic signed [W-1:0] b,
    input logic signed [W-1:0] c,
    input logic signed [W-1:0] d
  );
    logic signed [DW-1:0] dab;
    logic signed [DW-1:0] dcd;
    logic signed [TW-1:0] res;
    dab = DW'(a) - DW'(b);
    dcd = DW'(c) - DW'(d);
    unique case (sgn)
      SIGN_ZERO:    res = TW'(dab) + TW'(dcd);
      SIGN_POS:     res = TW'(dab) <<< 1;
      SIGN_NEG,
      SIGN_NEG_ALT: res = TW'(dcd) <<< 1;
    endcase
    return res;
  endfunction

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic                 rdy1, rdy2, rdy3, rdy4;
  logic                 in_acc;

  logic signed [TW-1:0] t0_q, t1_q, t2_q, t3_q;
  logic signed [DW-1:0] fs01_q, fs23_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q;
  logic signed [AW-1:0] total_q;
  logic signed [W-1:0]  edge_q, edge_d;
  logic                 ovf_q, ovf_d;

  logic signed [PW-1:0] fsum;
  logic signed [SW-1:0] sh;
  logic                 fits;

  // per-stage handshake, a stage moves when the next one can take it
  assign rdy4   = !v4_q || !out_stall_i;
  assign rdy3   = !v3_q || rdy4;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign in_acc = in_valid_i && rdy1;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: correction terms and face pair sums
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t0_q   <= corr(vel_sign_0_i, face_emf_3_i, cell_emf_3_i, face_emf_1_i, cell_emf_0_i);
      t1_q   <= corr(vel_sign_1_i, face_emf_2_i, cell_emf_1_i, face_emf_0_i, cell_emf_0_i);
      t2_q   <= corr(vel_sign_2_i, face_emf_3_i, cell_emf_2_i, face_emf_1_i, cell_emf_1_i);
      t3_q   <= corr(vel_sign_3_i, face_emf_2_i, cell_emf_2_i, face_emf_0_i, cell_emf_3_i);
      fs01_q <= DW'(face_emf_0_i) + DW'(face_emf_1_i);
      fs23_q <= DW'(face_emf_2_i) + DW'(face_emf_3_i);
    end
  end

  // stage 2: pair the terms, face average at eight times scale
  assign fsum = PW'(fs01_q) + PW'(fs23_q);

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      p0_q <= PW'(t0_q) + PW'(t1_q);
      p1_q <= PW'(t2_q) + PW'(t3_q);
      p2_q <= fsum <<< 1;
    end
  end

  // stage 3: exact total
  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      total_q <= AW'(p0_q) + AW'(p1_q) + AW'(p2_q);
    end
  end

  // stage 4: floor divide by eight and saturate
  assign sh   = total_q[AW-1:3];
  assign fits = (sh[SW-1] == sh[W-1]) && (sh[SW-2] == sh[W-1]);

  always_comb begin
    if (fits) begin
      edge_d = sh[W-1:0];
      ovf_d  = 1'b0;
    end else if (sh[SW-1]) begin
      edge_d = SAT_MIN;
      ovf_d  = 1'b1;
    end else begin
      edge_d = SAT_MAX;
      ovf_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && rdy4) begin
      edge_q <= edge_d;
      ovf_q  <= ovf_d;
    end
  end

  assign out_valid_o = v4_q;
  assign edge_emf_o  = edge_q;
  assign overflow_o  = ovf_q;

  // checks
  `ASSERT_PROP(a_sat_value, (out_valid_o && overflow_o) |-> ((edge_emf_o == SAT_MIN) || (edge_emf_o == SAT_MAX)), "overflow without saturated value")
  `ASSERT_PROP(a_acc_fills, in_acc |=> v1_q, "accepted request not in first stage")
  `ASSERT_NEVER(a_stall_empty, in_stall_o && !(v1_q && v2_q && v3_q && v4_q), "input stalled with a bubble in the pipeline")
  `ASSERT_PROP(a_out_fills, (v3_q && rdy4) |=> out_valid_o, "result lost between last stages")

endmodule
